/* rtl/core/lecg_pkg.sv */
// ----------------------------------------------------------------------------
// lecg_pkg
// Shared types, constants and the color wheel lookup for the LED effect
// color generator.
// ----------------------------------------------------------------------------
package lecg_pkg;

  localparam int unsigned DivBits       = 32;
  localparam int unsigned DivorBits     = 17;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = DivBits / StepsPerStage;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    RegModeFlags  = 3'd0,
    RegBaseColor  = 3'd1,
    RegPeakBright = 3'd2,
    RegOnTime     = 3'd3,
    RegOffTime    = 3'd4,
    RegWheelPer   = 3'd5
  } cfg_reg_e;

  localparam int unsigned ModeColorful = 0;
  localparam int unsigned ModeBreathe  = 1;
  localparam int unsigned ModeFlash    = 2;

  localparam logic [7:0] FullBright = 8'd255;

  // per-item flags that ride along the brightness divider
  typedef struct packed {
    logic rise;
    logic on_zero;
  } side_t;

  // six segments of 256 steps each
  function automatic logic [23:0] wheel_color(input logic [10:0] pos);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] f;
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    f = pos[7:0];
    case (pos[10:8])
      3'd0: begin r = 8'd255;     g = f;          end
      3'd1: begin r = 8'd255 - f; g = 8'd255;     end
      3'd2: begin g = 8'd255;     b = f;          end
      3'd3: begin g = 8'd255 - f; b = 8'd255;     end
      3'd4: begin r = f;          b = 8'd255;     end
      3'd5: begin r = 8'd255;     b = 8'd255 - f; end
      default: ;
    endcase
    return {r, g, b};
  endfunction

endpackage

/* rtl/core/led_effect_color_generator.sv */
// ----------------------------------------------------------------------------
// led_effect_color_generator
// Maps a millisecond timestamp to one RGB color with breathe, flash and
// color wheel effects.
// ----------------------------------------------------------------------------
//  channel   ports                                  transfer
//  input     start_i, busy_o, now_ms_i              start_i && !busy_o
//  result    valid_o, red_o, green_o, blue_o        valid_o, one cycle
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,  cfg_valid_i && cfg_ready_o
//            cfg_data_i
//
// one timestamp per cycle; each result passes through these registers in order:
// input register, two 16-stage divider pipelines (phase/wheel modulo, then
// brightness/wheel position) with a product register between them, a color
// stage and the scaling register.
// busy_o stays low; results cannot be held off, so nothing ever stalls.
// reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module led_effect_color_generator
  import lecg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [31:0]            now_ms_i,
  output logic                   valid_o,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned Latency = 2 * DivStages + 4;

  logic [2:0]  mode_q;
  logic [23:0] base_q;
  logic [7:0]  peak_q;
  logic [15:0] on_q;
  logic [15:0] off_q;
  logic [15:0] wheel_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 3'd0;
      base_q  <= 24'd0;
      peak_q  <= 8'd255;
      on_q    <= 16'd500;
      off_q   <= 16'd500;
      wheel_q <= 16'd3000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegModeFlags:  mode_q  <= cfg_data_i[2:0];
        RegBaseColor:  base_q  <= cfg_data_i;
        RegPeakBright: peak_q  <= cfg_data_i[7:0];
        RegOnTime:     on_q    <= cfg_data_i[15:0];
        RegOffTime:    off_q   <= cfg_data_i[15:0];
        RegWheelPer:   wheel_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_vld_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_ms_i;
  end

  logic [16:0] period;
  assign period = {1'b0, on_q} + {1'b0, off_q};

  // first pass: now mod period and now mod wheel period
  logic                 pa_vld;
  logic                 wa_vld;
  logic [DivBits-1:0]   pa_quot;
  logic [DivBits-1:0]   wa_quot;
  logic [DivorBits-1:0] pa_rem;
  logic [DivorBits-1:0] wa_rem;
  side_t                pa_side;
  side_t                wa_side;

  lecg_div u_phase_mod (
    .clk_i, .rst_ni,
    .valid_i    (in_vld_q),
    .dividend_i (now_q),
    .divisor_i  (period),
    .side_i     ('0),
    .valid_o    (pa_vld),
    .quot_o     (pa_quot),
    .rem_o      (pa_rem),
    .side_o     (pa_side)
  );

  lecg_div u_wheel_mod (
    .clk_i, .rst_ni,
    .valid_i    (in_vld_q),
    .dividend_i (now_q),
    .divisor_i  ({1'b0, wheel_q}),
    .side_i     ('0),
    .valid_o    (wa_vld),
    .quot_o     (wa_quot),
    .rem_o      (wa_rem),
    .side_o     (wa_side)
  );

  // brightness and wheel dividends
  logic [15:0] phase;
  logic [15:0] wmod;
  logic        rise;
  logic [15:0] ramp;
  logic [23:0] br_prod;
  logic [26:0] w_prod;

  assign phase   = (period == 17'd0) ? 16'd0 : pa_rem[15:0];
  assign wmod    = (wheel_q == 16'd0) ? 16'd0 : wa_rem[15:0];
  assign rise    = (phase <= on_q);
  assign ramp    = rise ? phase : (phase - on_q);
  assign br_prod = ramp * peak_q;
  assign w_prod  = ({11'd0, wmod} << 10) + ({11'd0, wmod} << 9);

  logic        pb_vld_q;
  logic [23:0] br_prod_q;
  logic [26:0] w_prod_q;
  logic [15:0] br_div_q;
  side_t       pb_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_vld_q <= 1'b0;
    end else begin
      pb_vld_q <= pa_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    br_prod_q         <= br_prod;
    w_prod_q          <= w_prod;
    br_div_q          <= rise ? on_q : off_q;
    pb_side_q.rise    <= rise;
    pb_side_q.on_zero <= (on_q == 16'd0);
  end

  logic                 bb_vld;
  logic                 wb_vld;
  logic [DivBits-1:0]   bb_quot;
  logic [DivBits-1:0]   wb_quot;
  logic [DivorBits-1:0] bb_rem;
  logic [DivorBits-1:0] wb_rem;
  side_t                bb_side;
  side_t                wb_side;

  lecg_div u_bright_div (
    .clk_i, .rst_ni,
    .valid_i    (pb_vld_q),
    .dividend_i ({8'd0, br_prod_q}),
    .divisor_i  ({1'b0, br_div_q}),
    .side_i     (pb_side_q),
    .valid_o    (bb_vld),
    .quot_o     (bb_quot),
    .rem_o      (bb_rem),
    .side_o     (bb_side)
  );

  lecg_div u_wheel_div (
    .clk_i, .rst_ni,
    .valid_i    (pb_vld_q),
    .dividend_i ({5'd0, w_prod_q}),
    .divisor_i  ({1'b0, wheel_q}),
    .side_i     ('0),
    .valid_o    (wb_vld),
    .quot_o     (wb_quot),
    .rem_o      (wb_rem),
    .side_o     (wb_side)
  );

  // color and brightness selection
  logic [7:0]  bright;
  logic [10:0] pos;
  logic [23:0] color;

  always_comb begin
    bright = peak_q;
    if (mode_q[ModeBreathe]) begin
      if (bb_side.rise) begin
        bright = bb_side.on_zero ? FullBright : bb_quot[7:0];
      end else begin
        bright = peak_q - bb_quot[7:0];
      end
    end else if (mode_q[ModeFlash]) begin
      bright = bb_side.rise ? peak_q : 8'd0;
    end
    pos   = (wheel_q == 16'd0) ? 11'd0 : wb_quot[10:0];
    color = mode_q[ModeColorful] ? wheel_color(pos) : base_q;
  end

  logic        cs_vld_q;
  logic [23:0] color_q;
  logic [7:0]  bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_vld_q <= 1'b0;
    end else begin
      cs_vld_q <= bb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q  <= color;
    bright_q <= bright;
  end

  // scaling stage
  logic [15:0] r_prod;
  logic [15:0] g_prod;
  logic [15:0] b_prod;
  logic        out_vld_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;

  assign r_prod = color_q[23:16] * bright_q;
  assign g_prod = color_q[15:8] * bright_q;
  assign b_prod = color_q[7:0] * bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cs_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bright_q == FullBright) begin
      red_q   <= color_q[23:16];
      green_q <= color_q[15:8];
      blue_q  <= color_q[7:0];
    end else begin
      red_q   <= r_prod[15:8];
      green_q <= g_prod[15:8];
      blue_q  <= b_prod[15:8];
    end
  end

  assign valid_o = out_vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // the two passes of parallel dividers stay in lockstep
  a_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pa_vld == wa_vld) && (bb_vld == wb_vld))
    else $error("divider pipelines out of step");

  a_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency valid_o)
    else $error("accepted timestamp produced no color");

  a_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("color without a matching timestamp");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_vld && wheel_q != 16'd0) |-> (wb_quot[DivBits-1:11] == '0))
    else $error("wheel position beyond one turn");

endmodule

/* rtl/core/lecg_div.sv */
// ----------------------------------------------------------------------------
// lecg_div
// Pipelined restoring divider, two quotient bits per stage, with a small
// sideband that travels with each item.
// ----------------------------------------------------------------------------
module lecg_div
  import lecg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [DivBits-1:0]   dividend_i,
  input  logic [DivorBits-1:0] divisor_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic [DivBits-1:0]   quot_o,
  output logic [DivorBits-1:0] rem_o,
  output side_t                side_o
);

  logic                 vld_q  [DivStages];
  logic [DivBits-1:0]   quo_q  [DivStages];
  logic [DivorBits-1:0] rem_q  [DivStages];
  logic [DivorBits-1:0] dvs_q  [DivStages];
  side_t                side_q [DivStages];

  logic                 vld_in  [DivStages];
  logic [DivBits-1:0]   quo_in  [DivStages];
  logic [DivorBits-1:0] rem_in  [DivStages];
  logic [DivorBits-1:0] dvs_in  [DivStages];
  side_t                side_in [DivStages];

  logic [DivBits-1:0]   quo_d [DivStages];
  logic [DivorBits-1:0] rem_d [DivStages];

  assign vld_in[0]  = valid_i;
  assign quo_in[0]  = dividend_i;
  assign rem_in[0]  = '0;
  assign dvs_in[0]  = divisor_i;
  assign side_in[0] = side_i;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign vld_in[s]  = vld_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign dvs_in[s]  = dvs_q[s-1];
      assign side_in[s] = side_q[s-1];
    end

    // quotient bits shift in where dividend bits shift out
    always_comb begin
      logic [DivorBits:0]   trial;
      logic [DivBits-1:0]   qv;
      logic [DivorBits-1:0] rv;
      qv = quo_in[s];
      rv = rem_in[s];
      for (int k = 0; k < StepsPerStage; k++) begin
        trial = {rv, qv[DivBits-1]};
        qv    = {qv[DivBits-2:0], 1'b0};
        if (trial >= {1'b0, dvs_in[s]}) begin
          trial = trial - {1'b0, dvs_in[s]};
          qv[0] = 1'b1;
        end
        rv = trial[DivorBits-1:0];
      end
      quo_d[s] = qv;
      rem_d[s] = rv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s]  <= quo_d[s];
      rem_q[s]  <= rem_d[s];
      dvs_q[s]  <= dvs_in[s];
      side_q[s] <= side_in[s];
    end
  end

  assign valid_o = vld_q[DivStages-1];
  assign quot_o  = quo_q[DivStages-1];
  assign rem_o   = rem_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule
